// ===== design/pcmsd_pkg.sv =====
package pcmsd_pkg;

  // block limits
  localparam int MAX_CHANNELS = 8;
  localparam int MAX_BYTES    = 4;

  // register indexes on the configuration port
  localparam logic [1:0] CFG_IDX_CHANNELS = 2'd0;
  localparam logic [1:0] CFG_IDX_BYTES    = 2'd1;
  localparam logic [1:0] CFG_IDX_UNSIGNED = 2'd2;

  // reset values of the registers
  localparam logic [3:0] CFG_RST_CHANNELS = 4'd2;
  localparam logic [2:0] CFG_RST_BYTES    = 3'd2;

  // result kinds carried through the queue
  localparam logic [1:0] KIND_PASS = 2'd0;  // left/right given as they are
  localparam logic [1:0] KIND_DIV  = 2'd1;  // sum / divisor to both sides
  localparam logic [1:0] KIND_ERR  = 2'd2;  // block ended mid-frame

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // reciprocal divide: floor(n/d) = (n * RECIP(d)) >> RECIP_SHIFT, exact for n < 2**19
  localparam int SUM_W       = 19;
  localparam int RECIP_W     = 21;
  localparam int RECIP_SHIFT = 22;
  localparam int PROD_W      = SUM_W + RECIP_W;

  typedef struct packed {
    logic [1:0]              kind;
    logic signed [15:0]      left;
    logic signed [15:0]      right;
    logic signed [SUM_W-1:0] sum;
    logic [3:0]              divisor;
  } entry_t;

  function automatic logic [RECIP_W-1:0] recip(input logic [3:0] d);
    logic [RECIP_W-1:0] m;
    unique case (d)
      4'd3:    m = 21'd1398102;
      4'd4:    m = 21'd1048576;
      4'd5:    m = 21'd838861;
      4'd6:    m = 21'd699051;
      4'd7:    m = 21'd599187;
      default: m = 21'd524288;
    endcase
    return m;
  endfunction

endpackage

// ===== design/pcmsd_front.sv =====
module pcmsd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [3:0]          cfg_data,
  input  logic                in_fire,
  input  logic [7:0]          in_data,
  input  logic                in_last,
  output logic                push,
  output pcmsd_pkg::entry_t   push_entry
);
  import pcmsd_pkg::*;

  logic [3:0]              cc_r;
  logic [2:0]              sb_r;
  logic                    u8_r;
  logic [1:0]              byte_pos_r, byte_pos_nxt;
  logic [2:0]              ch_pos_r, ch_pos_nxt;
  logic [15:0]             asm_r, asm_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic signed [15:0]      held_r, held_nxt;

  logic [3:0]              c_eff;
  logic [2:0]              s_eff;
  logic                    smp_done, frm_done;
  logic signed [15:0]      v;
  logic signed [SUM_W-1:0] sum_full;

  // out-of-range settings clamp
  assign c_eff = (cc_r == 4'd0) ? 4'd1 :
                 (cc_r > 4'(MAX_CHANNELS)) ? 4'(MAX_CHANNELS) : cc_r;
  assign s_eff = (sb_r == 3'd0) ? 3'd1 :
                 (sb_r > 3'(MAX_BYTES)) ? 3'(MAX_BYTES) : sb_r;

  assign asm_nxt  = {in_data, asm_r[15:8]};
  assign smp_done = (({1'b0, byte_pos_r} + 3'd1) >= s_eff);
  assign frm_done = smp_done && (({1'b0, ch_pos_r} + 4'd1) >= c_eff);
  assign v        = (s_eff == 3'd1) ? {in_data ^ {u8_r, 7'b0}, 8'h00} : asm_nxt;
  assign sum_full = sum_r + {{(SUM_W-16){v[15]}}, v};

  always_comb begin
    byte_pos_nxt = byte_pos_r;
    ch_pos_nxt   = ch_pos_r;
    sum_nxt      = sum_r;
    held_nxt     = held_r;
    push         = 1'b0;
    push_entry   = '0;
    if (in_fire) begin
      if (smp_done) begin
        byte_pos_nxt = 2'd0;
        if (frm_done) begin
          push = 1'b1;
          push_entry.divisor = c_eff;
          priority if (c_eff == 4'd1) begin
            push_entry.kind  = KIND_PASS;
            push_entry.left  = v;
            push_entry.right = v;
          end else if (c_eff == 4'd2) begin
            push_entry.kind  = KIND_PASS;
            push_entry.left  = held_r;
            push_entry.right = v;
          end else begin
            push_entry.kind = KIND_DIV;
            push_entry.sum  = sum_full;
          end
          ch_pos_nxt = 3'd0;
          sum_nxt    = '0;
        end else begin
          if (ch_pos_r == 3'd0) held_nxt = v;
          sum_nxt    = sum_full;
          ch_pos_nxt = ch_pos_r + 3'd1;
        end
      end else begin
        byte_pos_nxt = byte_pos_r + 2'd1;
      end
      // partial frame at end of block: drop it, report
      if (in_last && (byte_pos_nxt != 2'd0 || ch_pos_nxt != 3'd0)) begin
        push         = 1'b1;
        push_entry   = '0;
        push_entry.kind = KIND_ERR;
        byte_pos_nxt = 2'd0;
        ch_pos_nxt   = 3'd0;
        sum_nxt      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r       <= CFG_RST_CHANNELS;
      sb_r       <= CFG_RST_BYTES;
      u8_r       <= 1'b0;
      byte_pos_r <= '0;
      ch_pos_r   <= '0;
      asm_r      <= '0;
      sum_r      <= '0;
      held_r     <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_IDX_CHANNELS: cc_r <= cfg_data;
          CFG_IDX_BYTES:    sb_r <= cfg_data[2:0];
          CFG_IDX_UNSIGNED: u8_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_fire) asm_r <= asm_nxt;
      byte_pos_r <= byte_pos_nxt;
      ch_pos_r   <= ch_pos_nxt;
      sum_r      <= sum_nxt;
      held_r     <= held_nxt;
    end
  end

`ifndef SYNTH
  a_eob_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_last |=> byte_pos_r == 2'd0 && ch_pos_r == 3'd0)
    else $error("end of block left a partial frame");
  a_frame_clears_sum: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> sum_r == '0)
    else $error("channel sum not cleared after a result");
`endif

endmodule

// ===== design/pcmsd_queue.sv =====
module pcmsd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pcmsd_pkg::entry_t push_entry,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output pcmsd_pkg::entry_t head
);
  import pcmsd_pkg::*;

  entry_t         mem [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   count_r;

  assign full      = (count_r == (QAW+1)'(QDEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QAW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QAW'(1);
      unique case ({push, pop})
        2'b10:   count_r <= count_r + (QAW+1)'(1);
        2'b01:   count_r <= count_r - (QAW+1)'(1);
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue underflow");
`endif

endmodule

// ===== design/pcmsd_back.sv =====
module pcmsd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_not_empty,
  input  pcmsd_pkg::entry_t q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       out_left,
  output logic [15:0]       out_right,
  output logic              out_status
);
  import pcmsd_pkg::*;

  // stage 1: magnitude times reciprocal
  logic              st_valid_r;
  logic [1:0]        st_kind_r;
  logic [15:0]       st_left_r, st_right_r;
  logic [PROD_W-1:0] st_prod_r;
  logic              st_neg_r;

  // stage 2: output register
  logic              o_valid_r;
  logic [15:0]       o_left_r, o_right_r, o_left_nxt, o_right_nxt;
  logic              o_status_r, o_status_nxt;

  logic              adv;
  logic [SUM_W-1:0]  mag;
  logic [15:0]       quo;

  assign adv   = st_valid_r && (!o_valid_r || out_ready);
  assign q_pop = q_not_empty && (!st_valid_r || adv);
  assign mag   = q_head.sum[SUM_W-1] ? SUM_W'(-q_head.sum) : SUM_W'(q_head.sum);
  assign quo   = st_prod_r[RECIP_SHIFT +: 16];

  always_comb begin
    o_left_nxt   = st_left_r;
    o_right_nxt  = st_right_r;
    o_status_nxt = 1'b0;
    unique case (st_kind_r)
      KIND_DIV: begin
        o_left_nxt  = st_neg_r ? 16'(-quo) : quo;
        o_right_nxt = o_left_nxt;
      end
      KIND_ERR: begin
        o_left_nxt   = '0;
        o_right_nxt  = '0;
        o_status_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      st_kind_r  <= q_head.kind;
      st_left_r  <= q_head.left;
      st_right_r <= q_head.right;
      st_neg_r   <= q_head.sum[SUM_W-1];
      st_prod_r  <= mag * recip(q_head.divisor);
    end
    if (adv) begin
      o_left_r   <= o_left_nxt;
      o_right_r  <= o_right_nxt;
      o_status_r <= o_status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      if (q_pop)    st_valid_r <= 1'b1;
      else if (adv) st_valid_r <= 1'b0;
      if (adv)            o_valid_r <= 1'b1;
      else if (out_ready) o_valid_r <= 1'b0;
    end
  end

  assign out_valid  = o_valid_r;
  assign out_left   = o_left_r;
  assign out_right  = o_right_r;
  assign out_status = o_status_r;

`ifndef SYNTH
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_left == 16'd0 && out_right == 16'd0)
    else $error("error beat carries nonzero samples");
`endif

endmodule

// ===== design/pcm_to_stereo_s16_downmix.sv =====
// PCM byte stream to signed 16-bit stereo with multichannel downmix. Bytes of
// interleaved little-endian PCM enter one beat per cycle on in_*, one byte
// per beat, and each completed frame leaves as one stereo beat on out_*: mono
// is copied to both sides, stereo passes through, 3 to 8 channels are summed
// and divided by the channel count (toward zero) with the quotient on both
// sides. 8-bit samples are shifted up by 8 (unsigned ones first offset by
// 128); wider samples keep their top two bytes. A byte flagged in_tlast that
// leaves a frame unfinished yields one beat with status 1 and zero samples.
// The byte front end takes one beat every cycle as long as its four-entry
// result queue has room; the back end drains one result per cycle, unless
// out_tready holds the pipe, through a reciprocal multiply stage and an
// output register, which a result passes in turn after the queue before it
// is offered on out_*. Configuration is written through cfg_* (always
// ready) and must only change while the block is idle.
module pcm_to_stereo_s16_downmix (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,   // 0 channel_count, 1 sample_bytes, 2 unsigned_eight_bit
  input  logic [3:0]  cfg_data,
  // byte input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic        in_tlast,    // end_of_block
  // stereo output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [15:0] left_sample, [31:16] right_sample
  output logic [0:0]  out_tuser    // [0] status
);
  import pcmsd_pkg::*;

  logic   in_fire;
  logic   push, pop, q_full, q_not_empty;
  entry_t push_entry, q_head;
  logic [15:0] left, right;
  logic        status;

  assign cfg_ready = 1'b1;
  // a byte may produce a result, so hold off while the queue is full
  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  pcmsd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_fire    (in_fire),
    .in_data    (in_tdata),
    .in_last    (in_tlast),
    .push       (push),
    .push_entry (push_entry)
  );

  pcmsd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  pcmsd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_left    (left),
    .out_right   (right),
    .out_status  (status)
  );

  assign out_tdata = {right, left};
  assign out_tuser = status;

endmodule
